/* rtl/aes_pkg.sv */
// shared types, constants and byte-level functions for the aes block cipher unit
package aes_pkg;

  localparam int unsigned KeyWordsMax = 60;
  localparam int unsigned KeyAddrW    = $clog2(KeyWordsMax);
  localparam int unsigned CfgIdxW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_LENGTH = 3'd0,
    REG_KEY_0_7    = 3'd1,
    REG_KEY_8_15   = 3'd2,
    REG_KEY_16_23  = 3'd3,
    REG_KEY_24_31  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_len_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RND_FIRST,
    RND_MID,
    RND_LAST
  } round_kind_e;

  typedef logic [7:0] byte_t;

  function automatic byte_t xtime(byte_t x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t sbox_fwd(byte_t x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox_fwd = t[x];
  endfunction

  function automatic byte_t sbox_inv(byte_t x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    sbox_inv = t[x];
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    sub_word = {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
  endfunction

endpackage

/* rtl/aes_block_cipher_unit.sv */
// top level of the aes block cipher unit
//
// aes-128/192/256 encrypt and decrypt of one 128-bit block per transfer. the
// key schedule is expanded into four 15-word banks (60 words in all) one word
// per cycle on the first block after reset or after any register write (44,
// 52 or 60 words). a block then passes through a load step, which fetches the
// round key used first (four words, see below), and through the shared round
// unit once for the initial key addition and once per round, for 10, 12 or 14
// rounds, before the result is handed over. the input is not ready while a
// block is in flight; configuration transfers are taken only while idle and
// no block is offered, so a write never lands inside a block.
// round keys: four 32-bit words per round are kept in four banks, so one
// registered read per bank gives a whole round key each cycle.
module aes_block_cipher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [63:0] block_hi_i,
  input  logic [63:0] block_lo_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_hi_o,
  output logic [63:0] result_lo_o
);
  import aes_pkg::*;

  localparam int unsigned BankDepth = KeyWordsMax / 4;
  localparam int unsigned BankAw    = $clog2(BankDepth);

  // configuration registers
  logic [1:0]  key_len_q;
  logic [63:0] key_q [4];
  logic        stale_q;

  // sequencer
  ctrl_state_e st;
  logic [3:0]  round, nr, nk;
  logic [5:0]  exp_idx;
  logic        exp_last;

  // block state
  logic         dec_q;
  logic [127:0] blk_q, blk_d, rnd_out;
  round_kind_e  kind;

  // key expansion window: last nk words kept in a shift line
  logic [31:0] win_q [8];
  logic [31:0] new_w, temp_w, prev_w, back_w;
  logic [7:0]  rcon_q;
  logic [3:0]  pos_q;

  logic [127:0] rkey;
  logic [3:0]   key_round;
  logic         cfg_fire;

  // writes only while idle; a block offered in the same cycle goes first
  assign cfg_ready_o = (st == ST_IDLE) & ~in_valid_i;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= 2'(KEY_128);
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      stale_q   <= 1'b1;
    end else begin
      if (cfg_fire) begin
        case (cfg_index_i)
          REG_KEY_LENGTH: begin key_len_q <= cfg_data_i[1:0]; stale_q <= 1'b1; end
          REG_KEY_0_7:    begin key_q[0]  <= cfg_data_i;      stale_q <= 1'b1; end
          REG_KEY_8_15:   begin key_q[1]  <= cfg_data_i;      stale_q <= 1'b1; end
          REG_KEY_16_23:  begin key_q[2]  <= cfg_data_i;      stale_q <= 1'b1; end
          REG_KEY_24_31:  begin key_q[3]  <= cfg_data_i;      stale_q <= 1'b1; end
          default: ;
        endcase
      end else if (st == ST_EXPAND && exp_last) begin
        stale_q <= 1'b0;
      end
    end
  end

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .out_ready_i,
    .stale_i      (stale_q),
    .key_length_i (key_len_q),
    .in_ready_o,
    .out_valid_o,
    .state_o      (st),
    .round_o      (round),
    .nr_o         (nr),
    .exp_idx_o    (exp_idx),
    .nk_o         (nk),
    .exp_last_o   (exp_last)
  );

  // ---- key expansion, one word per cycle ----
  always_comb begin
    logic [63:0] r;
    r      = key_q[exp_idx[2:1]];
    prev_w = win_q[0];
    back_w = win_q[nk[2:0] - 3'd1];
    temp_w = prev_w;
    if (pos_q == 4'd0) begin
      temp_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk == 4'd8 && pos_q == 4'd4) begin
      temp_w = sub_word(prev_w);
    end
    if (exp_idx < {2'b00, nk}) begin
      new_w = exp_idx[0] ? r[31:0] : r[63:32];
    end else begin
      new_w = back_w ^ temp_w;
    end
  end

  // window holds newest word at slot 0; pos counts i mod nk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcon_q <= 8'h01;
      pos_q  <= '0;
    end else if (st == ST_IDLE) begin
      rcon_q <= 8'h01;
      pos_q  <= '0;
    end else if (st == ST_EXPAND) begin
      if (exp_idx >= {2'b00, nk} && pos_q == 4'd0) begin
        rcon_q <= xtime(rcon_q);
      end
      pos_q <= (pos_q == nk - 4'd1) ? 4'd0 : pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st == ST_EXPAND) begin
      win_q[0] <= new_w;
      for (int i = 1; i < 8; i++) win_q[i] <= win_q[i-1];
    end
  end

  // ---- round key banks, one per column ----
  always_comb begin
    if (st == ST_LOAD) begin
      key_round = dec_q ? nr : 4'd0;
    end else begin
      key_round = dec_q ? (nr - round - 4'd1) : (round + 4'd1);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    aes_ram #(.Width(32), .Depth(BankDepth)) u_bank (
      .clk_i,
      .we_i    (st == ST_EXPAND && exp_idx[1:0] == 2'(b)),
      .waddr_i (BankAw'(exp_idx[5:2])),
      .wdata_i (new_w),
      .raddr_i (BankAw'(key_round)),
      .rdata_o (rkey[127-32*b -: 32])
    );
  end

  // ---- shared round unit ----
  always_comb begin
    if (round == 4'd0) begin
      kind = RND_FIRST;
    end else if (round == nr) begin
      kind = RND_LAST;
    end else begin
      kind = RND_MID;
    end
  end

  aes_round u_round (
    .dec_i   (dec_q),
    .kind_i  (kind),
    .state_i (blk_q),
    .key_i   (rkey),
    .state_o (rnd_out)
  );

  always_comb begin
    blk_d = blk_q;
    if (st == ST_IDLE && in_valid_i) begin
      blk_d = {block_hi_i, block_lo_i};
    end else if (st == ST_ROUND) begin
      blk_d = rnd_out;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (st == ST_IDLE && in_valid_i) begin
      dec_q <= op_i;
    end
  end

  assign result_hi_o = blk_q[127:64];
  assign result_lo_o = blk_q[63:0];

  // ---- checks ----
  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st != ST_IDLE) |-> !in_ready_o) else $error("input ready while busy");
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(blk_q)) else $error("result moved");
  a_expand_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st == ST_EXPAND && exp_last && !cfg_fire) |=> !stale_q) else $error("stale kept");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st == ST_ROUND) |-> (round <= nr)) else $error("round overrun");
endmodule

/* rtl/aes_ram.sv */
// generic single-port-write ram with registered read
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/aes_round.sv */
// one aes round datapath, forward or inverse, shared over all rounds
module aes_round (
  input  logic                 dec_i,
  input  aes_pkg::round_kind_e kind_i,
  input  logic [127:0]         state_i,
  input  logic [127:0]         key_i,
  output logic [127:0]         state_o
);
  import aes_pkg::*;

  byte_t s   [16];
  byte_t sh  [16];
  byte_t sb  [16];
  byte_t mx  [16];
  byte_t ak  [16];
  byte_t res [16];
  byte_t k   [16];

  function automatic byte_t gmul(byte_t a, logic [3:0] b);
    byte_t x2, x4, x8, p;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    p = (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^ (b[2] ? x4 : 8'h00) ^ (b[3] ? x8 : 8'h00);
    gmul = p;
  endfunction

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
      k[i] = key_i[127-8*i -: 8];
    end
    // both directions shift then sub (the order does not matter: they commute)
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec_i) begin
          sh[4*((c+r)%4)+r] = s[4*c+r];
        end else begin
          sh[4*c+r] = s[4*((c+r)%4)+r];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = dec_i ? sbox_inv(sh[i]) : sbox_fwd(sh[i]);
    end
    for (int i = 0; i < 16; i++) begin
      ak[i] = sb[i] ^ k[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec_i) begin
          mx[4*c+r] = gmul(ak[4*c+((r+0)%4)], 4'd14) ^ gmul(ak[4*c+((r+1)%4)], 4'd11)
                    ^ gmul(ak[4*c+((r+2)%4)], 4'd13) ^ gmul(ak[4*c+((r+3)%4)], 4'd9);
        end else begin
          mx[4*c+r] = gmul(sb[4*c+((r+0)%4)], 4'd2) ^ gmul(sb[4*c+((r+1)%4)], 4'd3)
                    ^ sb[4*c+((r+2)%4)] ^ sb[4*c+((r+3)%4)];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      case (kind_i)
        RND_FIRST: res[i] = s[i] ^ k[i];
        RND_MID:   res[i] = dec_i ? mx[i] : (mx[i] ^ k[i]);
        RND_LAST:  res[i] = ak[i];
        default:   res[i] = s[i];
      endcase
    end
    for (int i = 0; i < 16; i++) begin
      state_o[127-8*i -: 8] = res[i];
    end
  end
endmodule

/* rtl/aes_ctrl.sv */
// sequencer: key expansion, round counting and handshakes
module aes_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          out_ready_i,
  input  logic                          stale_i,
  input  logic [1:0]                    key_length_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  output aes_pkg::ctrl_state_e          state_o,
  output logic [3:0]                    round_o,
  output logic [3:0]                    nr_o,
  output logic [5:0]                    exp_idx_o,
  output logic [3:0]                    nk_o,
  output logic                          exp_last_o
);
  import aes_pkg::*;

  ctrl_state_e st_q, st_d;
  logic [3:0]  round_q, round_d;
  logic [5:0]  exp_q, exp_d;
  logic [1:0]  code;
  logic [5:0]  total;

  assign code  = (key_length_i == 2'd3) ? 2'(KEY_256) : key_length_i;
  assign nk_o  = 4'd4 + {1'b0, code, 1'b0};
  assign nr_o  = nk_o + 4'd6;
  assign total = {nr_o + 4'd1, 2'b00};
  assign exp_last_o = (exp_q == total - 6'd1);

  always_comb begin
    st_d    = st_q;
    round_d = round_q;
    exp_d   = exp_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (stale_i) begin
            st_d  = ST_EXPAND;
            exp_d = '0;
          end else begin
            st_d = ST_LOAD;
          end
          round_d = '0;
        end
      end
      ST_EXPAND: begin
        exp_d = exp_q + 6'd1;
        if (exp_last_o) begin
          st_d = ST_LOAD;
        end
      end
      ST_LOAD:  st_d = ST_ROUND;
      ST_ROUND: begin
        round_d = round_q + 4'd1;
        if (round_q == nr_o) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (st_q == ST_IDLE);
    out_valid_o = (st_q == ST_DONE);
  end

  assign state_o   = st_q;
  assign round_o   = round_q;
  assign exp_idx_o = exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      round_q <= '0;
      exp_q   <= '0;
    end else begin
      st_q    <= st_d;
      round_q <= round_d;
      exp_q   <= exp_d;
    end
  end
endmodule
